@@ rtl/core/kbr_pkg.sv @@
package kbr_pkg;

  parameter int unsigned ADDR_BITS_DEF    = 40;
  parameter int unsigned BUCKET_DEPTH_DEF = 8;

  localparam int unsigned AW       = 40;
  localparam int unsigned IPW      = 32;
  localparam int unsigned PORTW    = 16;
  localparam int unsigned UNW      = 8;
  localparam int unsigned PICKW    = 9;
  localparam int unsigned BKW      = 6;
  localparam int unsigned LIMW     = 4;
  localparam int unsigned CFG_W    = 40;
  localparam int unsigned MAX_OUT  = 8;
  localparam logic [UNW-1:0] UN_MAX = 8'hFF;

  typedef enum logic [1:0] {
    REQ_SEEN    = 2'd0,
    REQ_PONG    = 2'd1,
    REQ_CLOSEST = 2'd2,
    REQ_PICK    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_NONE     = 3'd5
  } status_e;

  typedef enum logic {
    CFG_SELF  = 1'b0,
    CFG_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    req_e              req_type;
    logic [AW-1:0]     node_address;
    logic [IPW-1:0]    node_ip;
    logic [PORTW-1:0]  node_port;
    logic [PICKW-1:0]  pick_index;
  } kbr_req_t;

  typedef struct packed {
    status_e           status;
    logic [AW-1:0]     entry_address;
    logic [IPW-1:0]    entry_ip_out;
    logic [PORTW-1:0]  entry_port_out;
    logic [UNW-1:0]    unacked_count;
    logic [BKW-1:0]    bucket_index;
    logic              last_of_run;
  } kbr_rsp_t;

  typedef struct packed {
    logic [AW-1:0]     addr;
    logic [IPW-1:0]    ip;
    logic [PORTW-1:0]  port;
    logic [UNW-1:0]    unacked;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

@@ rtl/core/kbr_chan_if.sv @@
interface kbr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/kbr_ram.sv @@
module kbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/core/kbucket_routing_table_top.sv @@
// Channel  Dir  Payload    Beat
// req_i    in   kbr_req_t  one request per beat
// rsp_o    out  kbr_rsp_t  one result per beat, last_of_run ends a request
// cfg      in   we/idx/data one register write per cycle with cfg_we_i
// A seen, pong or closest request first searches the distance bits downward for its bucket,
// then reads the bucket count (S_FRD, S_FCHK) and the slots (S_SRD, S_SCHK); closest adds
// S_NEXT per slot and S_OUT per beat, and may visit every bucket.
// Ping pick walks bucket counts upward from bucket 0, with no bucket search.
// The input is not ready until the last result beat of a request is taken.
// Reset clears the bucket counts through per-bucket valid bits; no clearing pass.
module kbucket_routing_table_top #(
  parameter int unsigned ADDR_BITS    = kbr_pkg::ADDR_BITS_DEF,
  parameter int unsigned BUCKET_DEPTH = kbr_pkg::BUCKET_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  kbr_pkg::cfg_idx_e           cfg_idx_i,
  input  logic [kbr_pkg::CFG_W-1:0]   cfg_wdata_i,
  kbr_chan_if.sink                    req_i,
  kbr_chan_if.source                  rsp_o
);
  import kbr_pkg::*;

  localparam int unsigned NB  = ADDR_BITS;
  localparam int unsigned DB  = (ADDR_BITS < AW) ? ADDR_BITS : AW;
  localparam int unsigned BW  = $clog2(NB);
  localparam int unsigned NS  = NB * BUCKET_DEPTH;
  localparam int unsigned SW  = $clog2(NS);
  localparam int unsigned IW  = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned PW  = $clog2(NS + 1);
  localparam int unsigned CW  = ((PW > PICKW) ? PW : PICKW) + 1;
  localparam logic [LIMW-1:0] BD_L = LIMW'(BUCKET_DEPTH);
  localparam logic [LIMW-1:0] MO_L = LIMW'(MAX_OUT);
  localparam logic [BW-1:0] LAST_B = BW'(NB - 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FIND = 8'b0000_0010,
    S_FRD  = 8'b0000_0100,
    S_FCHK = 8'b0000_1000,
    S_SRD  = 8'b0001_0000,
    S_SCHK = 8'b0010_0000,
    S_NEXT = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  kbr_req_t req_q, req_d;
  kbr_rsp_t out_q, out_d, pend_q, pend_d;
  logic [AW-1:0] self_q;
  logic [LIMW-1:0] limit_q;
  logic [BW-1:0] cur_b_q, cur_b_d, home_b_q, home_b_d;
  logic up_q, up_d;
  logic [IW-1:0] i_q, i_d, n_q, n_d, n_cur;
  logic [LIMW-1:0] cnt_q, cnt_d, lim, cap;
  logic [PW-1:0] p_q, p_d;
  logic [DB-1:0] dist_q, dist_d;
  logic pend_vld_q, pend_vld_d, ret_next_q, ret_next_d;
  logic [NB-1:0] fill_vld_q, fill_vld_d;
  logic fill_rv_q;
  logic [LIMW-1:0] fill_rdata, fill_val, fill_wdata;
  logic fill_we, slot_we;
  logic [SW-1:0] slot_raddr, slot_waddr;
  slot_t slot_rd, slot_wdata;
  logic [SLOT_W-1:0] slot_rdata;
  logic do_miss, do_adv, do_fin;
  logic [UNW-1:0] un_new;
  kbr_rsp_t none_rsp;

  assign lim = (limit_q > BD_L) ? BD_L : limit_q;
  assign cap = (lim > MO_L) ? MO_L : lim;
  assign fill_val = fill_rv_q ? fill_rdata : '0;
  assign n_cur = (state_q == S_FCHK) ? IW'(fill_val) : n_q;
  assign slot_rd = slot_t'(slot_rdata);
  assign slot_raddr = SW'(int'(cur_b_q) * BUCKET_DEPTH + int'(i_q));
  assign un_new = (slot_rd.unacked == UN_MAX) ? UN_MAX : slot_rd.unacked + 1'b1;
  assign none_rsp = '{status: ST_NONE, last_of_run: 1'b1, default: '0};

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = (state_q == S_OUT);
  assign rsp_o.payload = out_q;

  kbr_ram #(.WIDTH(LIMW), .DEPTH(NB)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (cur_b_q),
    .wdata_i (fill_wdata),
    .raddr_i (cur_b_q),
    .rdata_o (fill_rdata)
  );

  kbr_ram #(.WIDTH(SLOT_W), .DEPTH(NS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    out_d      = out_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    ret_next_d = ret_next_q;
    cur_b_d    = cur_b_q;
    home_b_d   = home_b_q;
    up_d       = up_q;
    i_d        = i_q;
    n_d        = n_q;
    cnt_d      = cnt_q;
    p_d        = p_q;
    dist_d     = dist_q;
    fill_vld_d = fill_vld_q;
    fill_we    = 1'b0;
    fill_wdata = LIMW'(n_cur) + 1'b1;
    slot_we    = 1'b0;
    slot_waddr = slot_raddr;
    slot_wdata = slot_rd;
    do_miss    = 1'b0;
    do_adv     = 1'b0;
    do_fin     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d      = req_i.payload;
          dist_d     = DB'(req_i.payload.node_address ^ self_q);
          cnt_d      = '0;
          p_d        = '0;
          pend_vld_d = 1'b0;
          up_d       = 1'b0;
          if (req_i.payload.req_type == REQ_PICK) begin
            cur_b_d = '0;
            state_d = S_FRD;
          end else begin
            cur_b_d = BW'(DB - 1);
            state_d = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (dist_q[cur_b_q] || cur_b_q == '0) begin
          home_b_d = cur_b_q;
          state_d  = S_FRD;
        end else begin
          cur_b_d = cur_b_q - 1'b1;
        end
      end
      S_FRD: state_d = S_FCHK;
      S_FCHK: begin
        n_d = n_cur;
        i_d = '0;
        case (req_q.req_type)
          REQ_SEEN, REQ_PONG: begin
            if (n_cur == '0) do_miss = 1'b1;
            else state_d = S_SRD;
          end
          REQ_CLOSEST: begin
            if (cnt_q == cap) do_fin = 1'b1;
            else if (n_cur == '0) do_adv = 1'b1;
            else state_d = S_SRD;
          end
          default: begin
            if (CW'(p_q) + CW'(fill_val) > CW'(req_q.pick_index)) begin
              i_d     = IW'(CW'(req_q.pick_index) - CW'(p_q));
              state_d = S_SRD;
            end else begin
              p_d = p_q + PW'(fill_val);
              if (cur_b_q == LAST_B) begin
                out_d      = none_rsp;
                ret_next_d = 1'b0;
                state_d    = S_OUT;
              end else begin
                cur_b_d = cur_b_q + 1'b1;
                state_d = S_FRD;
              end
            end
          end
        endcase
      end
      S_SRD: state_d = S_SCHK;
      S_SCHK: begin
        case (req_q.req_type)
          REQ_SEEN, REQ_PONG: begin
            if (slot_rd.addr == req_q.node_address) begin
              slot_we    = 1'b1;
              slot_wdata = '{addr: slot_rd.addr, ip: req_q.node_ip, port: req_q.node_port,
                             unacked: (req_q.req_type == REQ_PONG) ? '0 : slot_rd.unacked};
              out_d = '{status: ST_UPDATED, entry_address: slot_rd.addr,
                        entry_ip_out: req_q.node_ip, entry_port_out: req_q.node_port,
                        unacked_count: slot_wdata.unacked, bucket_index: BKW'(cur_b_q),
                        last_of_run: 1'b1};
              ret_next_d = 1'b0;
              state_d    = S_OUT;
            end else if ((i_q + 1'b1) == n_q) begin
              do_miss = 1'b1;
            end else begin
              i_d     = i_q + 1'b1;
              state_d = S_SRD;
            end
          end
          REQ_CLOSEST: begin
            cnt_d      = cnt_q + 1'b1;
            pend_d     = '{status: ST_ENTRY, entry_address: slot_rd.addr,
                           entry_ip_out: slot_rd.ip, entry_port_out: slot_rd.port,
                           unacked_count: slot_rd.unacked, bucket_index: BKW'(cur_b_q),
                           last_of_run: 1'b0};
            pend_vld_d = 1'b1;
            if (pend_vld_q) begin
              out_d      = pend_q;
              ret_next_d = 1'b1;
              state_d    = S_OUT;
            end else begin
              state_d = S_NEXT;
            end
          end
          default: begin
            slot_we    = 1'b1;
            slot_wdata = '{addr: slot_rd.addr, ip: slot_rd.ip, port: slot_rd.port,
                           unacked: un_new};
            out_d = '{status: ST_ENTRY, entry_address: slot_rd.addr,
                      entry_ip_out: slot_rd.ip, entry_port_out: slot_rd.port,
                      unacked_count: un_new, bucket_index: BKW'(cur_b_q),
                      last_of_run: 1'b1};
            ret_next_d = 1'b0;
            state_d    = S_OUT;
          end
        endcase
      end
      S_NEXT: begin
        if (cnt_q == cap) begin
          do_fin = 1'b1;
        end else if ((i_q + 1'b1) < n_q) begin
          i_d     = i_q + 1'b1;
          state_d = S_SRD;
        end else begin
          do_adv = 1'b1;
        end
      end
      S_OUT: begin
        if (rsp_o.ready) begin
          state_d = ret_next_q ? S_NEXT : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (do_miss) begin
      ret_next_d = 1'b0;
      state_d    = S_OUT;
      if (req_q.req_type == REQ_PONG) begin
        out_d = '{status: ST_NOTFOUND, entry_address: req_q.node_address,
                  bucket_index: BKW'(cur_b_q), last_of_run: 1'b1, default: '0};
      end else if (LIMW'(n_cur) < lim) begin
        slot_we    = 1'b1;
        slot_waddr = SW'(int'(cur_b_q) * BUCKET_DEPTH + int'(n_cur));
        slot_wdata = '{addr: req_q.node_address, ip: req_q.node_ip,
                       port: req_q.node_port, unacked: '0};
        fill_we    = 1'b1;
        fill_vld_d[cur_b_q] = 1'b1;
        out_d = '{status: ST_INSERTED, entry_address: req_q.node_address,
                  entry_ip_out: req_q.node_ip, entry_port_out: req_q.node_port,
                  unacked_count: '0, bucket_index: BKW'(cur_b_q), last_of_run: 1'b1};
      end else begin
        out_d = '{status: ST_DROPPED, entry_address: req_q.node_address,
                  entry_ip_out: req_q.node_ip, entry_port_out: req_q.node_port,
                  unacked_count: '0, bucket_index: BKW'(cur_b_q), last_of_run: 1'b1};
      end
    end

    if (do_adv) begin
      if (!up_q) begin
        if (cur_b_q == '0) begin
          if (home_b_q == LAST_B) begin
            do_fin = 1'b1;
          end else begin
            cur_b_d = home_b_q + 1'b1;
            up_d    = 1'b1;
            state_d = S_FRD;
          end
        end else begin
          cur_b_d = cur_b_q - 1'b1;
          state_d = S_FRD;
        end
      end else if (cur_b_q == LAST_B) begin
        do_fin = 1'b1;
      end else begin
        cur_b_d = cur_b_q + 1'b1;
        state_d = S_FRD;
      end
    end

    if (do_fin) begin
      if (pend_vld_q) begin
        out_d             = pend_q;
        out_d.last_of_run = 1'b1;
      end else begin
        out_d = none_rsp;
      end
      pend_vld_d = 1'b0;
      ret_next_d = 1'b0;
      state_d    = S_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      self_q     <= '0;
      limit_q    <= BD_L;
      fill_vld_q <= '0;
      fill_rv_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      ret_next_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      fill_vld_q <= fill_vld_d;
      fill_rv_q  <= fill_vld_q[cur_b_q];
      pend_vld_q <= pend_vld_d;
      ret_next_q <= ret_next_d;
      cnt_q      <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SELF:  self_q  <= cfg_wdata_i[AW-1:0];
          CFG_LIMIT: limit_q <= cfg_wdata_i[LIMW-1:0];
          default:   limit_q <= limit_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    out_q    <= out_d;
    pend_q   <= pend_d;
    cur_b_q  <= cur_b_d;
    home_b_q <= home_b_d;
    up_q     <= up_d;
    i_q      <= i_d;
    n_q      <= n_d;
    p_q      <= p_d;
    dist_q   <= dist_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_we |-> fill_wdata <= BD_L)
    else $error("bucket count written beyond bucket depth");

  a_slot_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_we |-> (state_q == S_FCHK || state_q == S_SCHK))
    else $error("slot write outside a check state");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MO_L)
    else $error("closest count exceeds reply size");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid))
    else $error("input ready while a result beat is pending");

  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.ready && !ret_next_q) |=> req_i.ready)
    else $error("block not idle after the last result beat");
endmodule
